@@ rtl/aesd_pkg.sv @@
`default_nettype none
package aesd_pkg;

  localparam int KEY_BYTES   = 16;
  localparam int ROUNDS      = 10;
  localparam int NK          = KEY_BYTES / 4;
  localparam int SCHED_WORDS = 4 * (ROUNDS + 1);
  localparam int RK_DEPTH    = ROUNDS + 1;
  localparam int RK_AW       = $clog2(RK_DEPTH);
  localparam int WI_W        = $clog2(SCHED_WORDS);
  localparam int POS_W       = (NK > 1) ? $clog2(NK) : 1;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } plain_t;

  typedef logic [7:0] tbl_t [256];

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
    rotl8 = (x << n) | (x >> (8 - n));
  endfunction

  function automatic tbl_t gen_sbox();
    tbl_t t;
    logic [7:0] p;
    logic [7:0] q;
    p = 8'h01;
    q = 8'h01;
    for (int k = 0; k < 255; k++) begin
      p = p ^ (p << 1) ^ (p[7] ? 8'h1b : 8'h00);
      q = q ^ (q << 1);
      q = q ^ (q << 2);
      q = q ^ (q << 4);
      if (q[7]) q = q ^ 8'h09;
      t[p] = q ^ rotl8(q, 1) ^ rotl8(q, 2) ^ rotl8(q, 3) ^ rotl8(q, 4) ^ 8'h63;
    end
    t[0] = 8'h63;
    return t;
  endfunction

  function automatic tbl_t gen_inv(input tbl_t s);
    tbl_t t;
    for (int x = 0; x < 256; x++) t[s[x]] = 8'(x);
    return t;
  endfunction

  localparam tbl_t SBOX     = gen_sbox();
  localparam tbl_t INV_SBOX = gen_inv(SBOX);

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] inv_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[4*c+r] = INV_SBOX[s[127 - 8*(4*((c + 4 - r) % 4) + r) -: 8]]
                   ^ rk[127 - 8*(4*c+r) -: 8];
    for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = t[i];
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        for (int j = 0; j < 4; j++) begin
          x2[j] = xtime(t[4*c+j]);
          x4[j] = xtime(x2[j]);
          x8[j] = xtime(x4[j]);
        end
        a0 = x8[0] ^ x4[0] ^ x2[0];
        a1 = x8[1] ^ x2[1] ^ t[4*c+1];
        a2 = x8[2] ^ x4[2] ^ t[4*c+2];
        a3 = x8[3] ^ t[4*c+3];
        o[127 - 8*(4*c) -: 8] = a0 ^ a1 ^ a2 ^ a3;
        a0 = x8[0] ^ t[4*c];
        a1 = x8[1] ^ x4[1] ^ x2[1];
        a2 = x8[2] ^ x2[2] ^ t[4*c+2];
        a3 = x8[3] ^ x4[3] ^ t[4*c+3];
        o[127 - 8*(4*c+1) -: 8] = a0 ^ a1 ^ a2 ^ a3;
        a0 = x8[0] ^ x4[0] ^ t[4*c];
        a1 = x8[1] ^ t[4*c+1];
        a2 = x8[2] ^ x4[2] ^ x2[2];
        a3 = x8[3] ^ x2[3] ^ t[4*c+3];
        o[127 - 8*(4*c+2) -: 8] = a0 ^ a1 ^ a2 ^ a3;
        a0 = x8[0] ^ x2[0] ^ t[4*c];
        a1 = x8[1] ^ x4[1] ^ t[4*c+1];
        a2 = x8[2] ^ t[4*c+2];
        a3 = x8[3] ^ x4[3] ^ x2[3];
        o[127 - 8*(4*c+3) -: 8] = a0 ^ a1 ^ a2 ^ a3;
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

@@ rtl/aesd_ram.sv @@
`default_nettype none
module aesd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/aes_block_decrypt_unit.sv @@
`default_nettype none
// AES inverse cipher, one block at a time, one round per cycle.
// Each block passes through the initial key addition, ROUNDS rounds and the
// output load, in that order.
// The round unit is shared, so no new block is taken until the last is output.
// Reset loads the all-zero key and expands it; expansion also follows every
// key write, and input is stalled while it runs.
module aes_block_decrypt_unit import aesd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire cipher_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output plain_t           out_data
);

  typedef enum logic [3:0] {
    IDLE  = 4'b0001,
    INIT  = 4'b0010,
    ROUND = 4'b0100,
    DONE  = 4'b1000
  } st_t;

  logic [63:0]      key_word [4];
  logic             expanding;
  logic [WI_W-1:0]  wi;
  logic [POS_W-1:0] pos;
  logic [7:0]       rc;
  logic [31:0]      win [NK];
  logic [31:0]      t;
  logic [31:0]      w_new;
  logic [255:0]     key_all;
  logic             cfg_wr;

  st_t              st;
  logic [RK_AW-1:0] rnd;
  logic [RK_AW-1:0] raddr;
  logic [127:0]     blk;
  logic [63:0]      rk_hi, rk_lo;
  logic             we_hi, we_lo;
  logic             in_acc;
  logic             out_load;

  assign pready = 1'b1;
  assign prdata = key_word[paddr[4:3]];
  assign cfg_wr = psel && penable && pwrite;
  assign key_all = {key_word[0], key_word[1], key_word[2], key_word[3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) key_word[k] <= '0;
    end else if (cfg_wr) begin
      key_word[paddr[4:3]] <= pwdata;
    end
  end

  always_comb begin
    t = win[NK-1];
    if (pos == '0) begin
      t = {SBOX[win[NK-1][23:16]] ^ rc, SBOX[win[NK-1][15:8]],
           SBOX[win[NK-1][7:0]], SBOX[win[NK-1][31:24]]};
    end else if (NK > 6 && 32'(pos) == 32'd4) begin
      t = {SBOX[win[NK-1][31:24]], SBOX[win[NK-1][23:16]],
           SBOX[win[NK-1][15:8]], SBOX[win[NK-1][7:0]]};
    end
    if (32'(wi) < NK) w_new = key_all[255 - 32*wi -: 32];
    else w_new = win[0] ^ t;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      expanding <= 1'b1;
      wi        <= '0;
      pos       <= '0;
      rc        <= 8'h01;
    end else if (expanding) begin
      if (32'(wi) >= NK) begin
        if (pos == '0) rc <= xtime(rc);
      end
      pos <= (32'(pos) == NK - 1) ? '0 : pos + 1'b1;
      if (32'(wi) == SCHED_WORDS - 1) expanding <= 1'b0;
      else wi <= wi + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (expanding) begin
      for (int k = 0; k < NK - 1; k++) win[k] <= win[k+1];
      win[NK-1] <= w_new;
    end
  end

  assign we_hi = expanding && wi[0] && !wi[1];
  assign we_lo = expanding && wi[0] && wi[1];

  always_comb begin
    case (st)
      IDLE:    raddr = RK_AW'(ROUNDS);
      INIT:    raddr = rnd;
      default: raddr = rnd - 1'b1;
    endcase
  end

  aesd_ram #(.WIDTH(64), .DEPTH(RK_DEPTH)) u_ram_hi (
    .clk   (clk),
    .we    (we_hi),
    .waddr (wi[RK_AW+1:2]),
    .wdata ({win[NK-1], w_new}),
    .raddr (raddr),
    .rdata (rk_hi)
  );

  aesd_ram #(.WIDTH(64), .DEPTH(RK_DEPTH)) u_ram_lo (
    .clk   (clk),
    .we    (we_lo),
    .waddr (wi[RK_AW+1:2]),
    .wdata ({win[NK-1], w_new}),
    .raddr (raddr),
    .rdata (rk_lo)
  );

  assign in_stall = (st != IDLE) || expanding;
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (st == DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= IDLE;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (st)
        IDLE: begin
          if (in_acc) begin
            blk <= in_data;
            rnd <= RK_AW'(ROUNDS - 1);
            st  <= INIT;
          end
        end
        INIT: begin
          blk <= blk ^ {rk_hi, rk_lo};
          st  <= ROUND;
        end
        ROUND: begin
          blk <= inv_round(blk, {rk_hi, rk_lo}, rnd != '0);
          if (rnd == '0) st <= DONE;
          else rnd <= rnd - 1'b1;
        end
        DONE: begin
          if (out_load) begin
            out_data <= blk;
            st       <= IDLE;
          end
        end
        default: st <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ dv/aesd_checker.sv @@
module aesd_checker import aesd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire cipher_t     in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire plain_t      out_data,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCHED = 4 * (ROUNDS + 1);

  logic [7:0] fwd_box [256];
  logic [7:0] rev_box [256];
  logic [63:0] key_regs [4];
  logic [31:0] sched_words [SCHED];
  plain_t plain_fifo [$];
  int err_count = 0;

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = dbl(a);
    end
    return p;
  endfunction

  task automatic build_boxes();
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gmul(inv, 8'(x));
      if (x == 0) inv = 8'h00;
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_box[x] = b;
      rev_box[b] = 8'(x);
    end
  endtask

  task automatic expand_schedule();
    logic [7:0] t [4];
    logic [7:0] t0, rc;
    logic [63:0] kw;
    rc = 8'h01;
    for (int i = 0; i < SCHED; i++) sched_words[i] = '0;
    for (int i = 0; i < NK; i++) begin
      kw = key_regs[i / 2];
      sched_words[i] = (i % 2) ? kw[31:0] : kw[63:32];
    end
    for (int i = NK; i < SCHED; i++) begin
      for (int j = 0; j < 4; j++) t[j] = sched_words[i-1][31 - 8*j -: 8];
      if (i % NK == 0) begin
        t0 = t[0];
        t[0] = fwd_box[t[1]] ^ rc;
        t[1] = fwd_box[t[2]];
        t[2] = fwd_box[t[3]];
        t[3] = fwd_box[t0];
        rc = dbl(rc);
      end else if (NK > 6 && i % NK == 4) begin
        for (int j = 0; j < 4; j++) t[j] = fwd_box[t[j]];
      end
      sched_words[i] = sched_words[i-NK] ^ {t[0], t[1], t[2], t[3]};
    end
  endtask

  function automatic logic [127:0] rkey(input int k);
    return {sched_words[4*k], sched_words[4*k+1], sched_words[4*k+2], sched_words[4*k+3]};
  endfunction

  function automatic plain_t decrypt_block(input cipher_t c);
    logic [127:0] s, t;
    logic [7:0] a0, a1, a2, a3;
    s = {c.cipher_high, c.cipher_low} ^ rkey(ROUNDS);
    for (int r = ROUNDS - 1; r >= 0; r--) begin
      for (int col = 0; col < 4; col++)
        for (int row = 0; row < 4; row++)
          t[127 - 8*(4*col+row) -: 8] = rev_box[s[127 - 8*(4*((col+4-row)%4)+row) -: 8]];
      s = t ^ rkey(r);
      if (r > 0) begin
        for (int col = 0; col < 4; col++) begin
          a0 = s[127 - 32*col -: 8];
          a1 = s[119 - 32*col -: 8];
          a2 = s[111 - 32*col -: 8];
          a3 = s[103 - 32*col -: 8];
          s[127 - 32*col -: 32] = {
            gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9),
            gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13),
            gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11),
            gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14)};
        end
      end
    end
    return plain_t'(s);
  endfunction

  initial begin
    build_boxes();
    for (int i = 0; i < 4; i++) key_regs[i] = '0;
    expand_schedule();
  end

  assign errors  = err_count;
  assign pending = plain_fifo.size();

  always @(posedge clk) begin
    plain_t exp_p;
    if (rst) begin
      plain_fifo.delete();
      for (int i = 0; i < 4; i++) key_regs[i] = '0;
      expand_schedule();
    end else begin
      if (psel && penable && pwrite && pready) begin
        key_regs[paddr[4:3]] = pwdata;
        expand_schedule();
      end
      if (in_valid && !in_stall) plain_fifo.push_back(decrypt_block(in_data));
      if (out_valid && !out_stall) begin
        if (plain_fifo.size() == 0) begin
          $display("%0t: unexpected plaintext %h", $time, out_data);
          err_count++;
        end else begin
          exp_p = plain_fifo.pop_front();
          if (out_data.plain_high !== exp_p.plain_high) begin
            $display("%0t: plain_high expected %h actual %h", $time, exp_p.plain_high,
                     out_data.plain_high);
            err_count++;
          end
          if (out_data.plain_low !== exp_p.plain_low) begin
            $display("%0t: plain_low expected %h actual %h", $time, exp_p.plain_low,
                     out_data.plain_low);
            err_count++;
          end
        end
      end
    end
  end
endmodule

@@ dv/tb_aes_block_decrypt_unit.sv @@
module tb_aes_block_decrypt_unit;
  import aesd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  cipher_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  plain_t out_data;
  int errors, pending;
  int idle_cycles = 0;
  int stall_mode = 0;

  always #5 clk = ~clk;

  aes_block_decrypt_unit u_dut (.*);

  aesd_checker u_chk (.*);

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      default: return rand64();
    endcase
  endfunction

  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_aes_block_decrypt_unit failed");
      $finish;
    end
  end

  task automatic send_block(input cipher_t c);
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic hold_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 20)) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * ROUNDS + 10) @(posedge clk);
  endtask

  task automatic write_key(input int idx, input logic [63:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 5'(8 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int n);
    int burst;
    int sent;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < n; i++) begin
        send_block({rand_word(), rand_word()});
        sent++;
      end
      if ($urandom_range(0, 3) != 0) hold_gap();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_block({64'h0, 64'h0});
    send_block({64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff});
    send_block({64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a});
    send_block({64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001});
    drain();
    write_key(0, 64'h0001_0203_0405_0607);
    write_key(1, 64'h0809_0a0b_0c0d_0e0f);
    write_key(2, 64'h1011_1213_1415_1617);
    write_key(3, 64'h1819_1a1b_1c1d_1e1f);
    send_block({64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a});
    send_block({64'h0, 64'hffff_ffff_ffff_ffff});
    send_block({64'hffff_ffff_ffff_ffff, 64'h0});
    run_random(200);
    drain();
    for (int i = 0; i < 4; i++) write_key(i, '1);
    send_block({64'h0, 64'h0});
    send_block({64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff});
    run_random(200);
    drain();
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < 4; i++) write_key(i, rand64());
      run_random(150);
      drain();
    end
    if (errors == 0) begin
      $display("tb_aes_block_decrypt_unit passed");
    end else begin
      $display("tb_aes_block_decrypt_unit failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/aesd_pkg.sv
rtl/aesd_ram.sv
rtl/aes_block_decrypt_unit.sv
dv/aesd_checker.sv
dv/tb_aes_block_decrypt_unit.sv
